// File: rtl/oimu_pkg.sv
// Shared types and constants for the odometry/IMU frame receiver.
// No dependencies; imported by the front end, back end and top level.
`default_nettype none

package oimu_pkg;

    localparam logic [7:0] HEADER_BYTE   = 8'hFE;
    localparam int         PAYLOAD_BYTES = 16;
    localparam int         STORE_DEPTH   = PAYLOAD_BYTES - 1;
    localparam int         COUNT_W       = $clog2(PAYLOAD_BYTES);
    localparam int         GAIN_W        = 16;
    localparam int         VEL_W         = 11;
    localparam int         WORD_W        = 17;
    localparam logic [WORD_W-1:0] WORD_OFFSET = 17'd10000;
    localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd4096;

    // Configuration register indexes
    localparam logic [1:0] CFG_FORWARD_GAIN  = 2'd0;
    localparam logic [1:0] CFG_SIDEWAYS_GAIN = 2'd1;
    localparam logic [1:0] CFG_TURN_GAIN     = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT1 = 2'd0,
        PH_HUNT2 = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    // One complete frame handed from the front to the back.
    typedef struct packed {
        logic                         bad_sum;
        logic [STORE_DEPTH-1:0][7:0]  payload;
    } frame_t;

    typedef struct packed {
        logic                    we;
        logic [1:0]              index;
        logic [GAIN_W-1:0]       data;
    } cfg_write_t;

endpackage

`default_nettype wire

// File: rtl/oimu_front.sv
// Front end: header hunt, payload capture and checksum of the byte stream.
// Depends on oimu_pkg; pushes finished frames into oimu_queue.
`default_nettype none

module oimu_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            byte_valid,
    input  wire logic [7:0]      byte_data,
    output logic                 byte_ready,
    output oimu_pkg::frame_t     frame,
    output logic                 frame_push,
    input  wire logic            queue_full
);
    import oimu_pkg::*;

    phase_t                      phase_reg, phase_next;
    logic [COUNT_W-1:0]          count_reg, count_next;
    logic [7:0]                  sum_reg, sum_next;
    logic [STORE_DEPTH-1:0][7:0] store_reg;
    logic                        accept;
    logic                        last_byte;
    logic                        store_we;

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;
    assign last_byte  = (count_reg == COUNT_W'(PAYLOAD_BYTES - 1));

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT1:
            begin
                if (accept && byte_data == HEADER_BYTE)
                    phase_next = PH_HUNT2;
            end
            PH_HUNT2:
            begin
                if (accept)
                    phase_next = (byte_data == HEADER_BYTE) ? PH_DATA : PH_HUNT1;
            end
            PH_DATA:
            begin
                if (accept && last_byte)
                    phase_next = PH_HUNT1;
            end
            default:
            begin
                if (accept)
                    phase_next = (byte_data == HEADER_BYTE) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        store_we   = 1'b0;
        frame_push = 1'b0;
        count_next = count_reg;
        sum_next   = sum_reg;
        unique case (phase_reg)
            PH_HUNT2:
            begin
                if (accept && byte_data == HEADER_BYTE)
                begin
                    count_next = '0;
                    sum_next   = '0;
                end
            end
            PH_DATA:
            begin
                if (accept)
                begin
                    if (last_byte)
                    begin
                        frame_push = 1'b1;
                        count_next = '0;
                        sum_next   = '0;
                    end
                    else
                    begin
                        store_we   = 1'b1;
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + byte_data;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign frame.bad_sum = (sum_reg != byte_data);
    assign frame.payload = store_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT1;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // payload bytes: written in order, no reset needed
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_reg[count_reg] <= byte_data;
    end

endmodule

`default_nettype wire

// File: rtl/oimu_queue.sv
// Short register queue decoupling the front end from the back end.
// Generic in width and depth; no package dependency.
`default_nettype none

module oimu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      head
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][WIDTH-1:0] entry_reg;
    logic [AW-1:0]               wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]               rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]               count_reg, count_next;
    logic                        do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// File: rtl/oimu_back.sv
// Back end: gain registers, velocity scaling and word unpacking, output register.
// Depends on oimu_pkg; pops frames from oimu_queue.
`default_nettype none

module oimu_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire oimu_pkg::cfg_write_t cfg,
    input  wire logic                 frame_avail,
    input  wire oimu_pkg::frame_t     frame,
    output logic                      frame_pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      out_status,
    output logic [134:0]              out_data
);
    import oimu_pkg::*;

    localparam int PROD_W = 8 + GAIN_W;

    logic signed [GAIN_W-1:0]      gain_reg [3];
    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_bad_reg;
    logic signed [PROD_W-1:0]      prod_reg [3];
    logic [STORE_DEPTH-1:0][7:0]   s1_bytes_reg;
    logic                          out_valid_reg;
    logic                          out_bad_reg;
    logic [134:0]                  out_data_reg;
    logic                          out_ok;
    logic                          s1_free;
    logic [134:0]                  data_next;

    // round half up then clamp to the velocity range
    function automatic logic [VEL_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0]     biased;
        logic signed [PROD_W-12:0]  q;
        begin
            biased = {p[PROD_W-1], p} + (PROD_W+1)'(2048);
            q      = biased[PROD_W:12];
            if (q > (PROD_W-11)'(signed'(1023)))
                round_sat = VEL_W'(1023);
            else if (q < -(PROD_W-11)'(signed'(1024)))
                round_sat = {1'b1, {(VEL_W-1){1'b0}}};
            else
                round_sat = q[VEL_W-1:0];
        end
    endfunction

    assign out_ok    = !out_valid_reg || out_ready;
    assign s1_free   = !s1_valid_reg || out_ok;
    assign frame_pop = frame_avail && s1_free;

    always_comb
    begin
        if (frame_pop)
            s1_valid_next = 1'b1;
        else if (out_ok)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    // gains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg[0] <= GAIN_RESET;
            gain_reg[1] <= GAIN_RESET;
            gain_reg[2] <= GAIN_RESET;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                CFG_FORWARD_GAIN:  gain_reg[0] <= signed'(cfg.data);
                CFG_SIDEWAYS_GAIN: gain_reg[1] <= signed'(cfg.data);
                CFG_TURN_GAIN:     gain_reg[2] <= signed'(cfg.data);
                default:
                begin
                end
            endcase
        end
    end

    // stage 1: byte offset times gain
    always_ff @(posedge clk)
    begin
        if (frame_pop)
        begin
            s1_bad_reg   <= frame.bad_sum;
            s1_bytes_reg <= frame.payload;
            for (int i = 0; i < 3; i++)
                prod_reg[i] <= PROD_W'(signed'(frame.payload[i] ^ 8'h80)) *
                               PROD_W'(gain_reg[i]);
        end
    end

    // stage 2: rounding, saturation and word unpacking
    always_comb
    begin
        data_next = '0;
        if (!s1_bad_reg)
        begin
            data_next[10:0]  = round_sat(prod_reg[0]);
            data_next[21:11] = round_sat(prod_reg[1]);
            data_next[32:22] = round_sat(prod_reg[2]);
            for (int k = 0; k < 6; k++)
                data_next[33 + WORD_W*k +: WORD_W] =
                    {1'b0, s1_bytes_reg[4 + 2*k], s1_bytes_reg[3 + 2*k]} - WORD_OFFSET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (out_ok)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ok && s1_valid_reg)
        begin
            out_bad_reg  <= s1_bad_reg;
            out_data_reg <= data_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_bad_reg;
    assign out_data   = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/odometry_imu_frame_receiver.sv
// Top level of the odometry/IMU frame receiver: front end, frame queue, back end.
// Depends on oimu_pkg, oimu_front, oimu_queue and oimu_back.
`default_nettype none

// Channel   Direction  Width  Contents
// s_axis    in         8      received serial byte (s_tdata)
// m_axis    out        136+1  one decoded frame per beat; tuser = checksum mismatch
// cfg       in         2+16   gain register index and value
//
// One byte beat is taken every cycle while s_tready is high; a frame (two header
// bytes, 15 payload bytes, a checksum byte) gives one result beat via the queue.
// The back end is a two-stage pipeline (multiply, then round/unpack) behind a
// QUEUE_DEPTH-entry frame queue; s_tready drops only when that queue is full.
// Reset: hunting the first header byte, gains at 1.0 (4096), queue empty.
// A stalled m_axis holds its beat; bytes keep flowing until the queue fills.
module odometry_imu_frame_receiver #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // byte stream in
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
    // frame results out
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata,   // vel_forward, vel_sideways, vel_turn (11 b each),
                                         // accel_x/y/z, rate_x/y/z (17 b each), 1 b zero pad
    output logic              m_tuser,   // status: 1 = checksum mismatch
    // gain register writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    import oimu_pkg::*;

    frame_t     front_frame;
    frame_t     queue_head;
    logic       frame_push;
    logic       queue_full;
    logic       queue_avail;
    logic       frame_pop;
    cfg_write_t cfg_wr;
    logic [134:0] result_data;

    // gain writes are always taken
    assign cfg_ready    = 1'b1;
    assign cfg_wr.we    = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    oimu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_tvalid),
        .byte_data  (s_tdata),
        .byte_ready (s_tready),
        .frame      (front_frame),
        .frame_push (frame_push),
        .queue_full (queue_full)
    );

    oimu_queue #(
        .WIDTH ($bits(frame_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (frame_push),
        .push_data (front_frame),
        .full      (queue_full),
        .pop       (frame_pop),
        .not_empty (queue_avail),
        .head      (queue_head)
    );

    oimu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_wr),
        .frame_avail (queue_avail),
        .frame       (queue_head),
        .frame_pop   (frame_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (m_tuser),
        .out_data    (result_data)
    );

    assign m_tdata = {1'b0, result_data};

endmodule

`default_nettype wire

// File: tb/tb_odometry_imu_frame_receiver.sv
`timescale 1ns / 100ps
// Self-checking testbench for odometry_imu_frame_receiver: byte stream in, decoded frames out.
// Depends on oimu_pkg and the RTL top level; a built-in decoder predicts every frame beat.

module tb_odometry_imu_frame_receiver;

    import oimu_pkg::*;

    // ---------------------------------------------------------------------------------
    // Run constants
    // ---------------------------------------------------------------------------------
    localparam int          CLK_HALF     = 4;
    localparam int          RESET_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 400000;
    // settle time after the last due result beat, with a margin
    localparam int          SETTLE_CYCLES = 12;
    localparam int          PHASE_BYTES   = 280;
    localparam int          GAIN_PHASES   = 6;
    localparam int          DIRECTED_ROWS = 6;

    // Velocity arithmetic: Q4.12 gain on (byte - 128), round half up, saturate
    localparam int          VEL_OFFSET = 128;
    localparam int          ROUND_HALF = 2048;
    localparam int          FRAC_BITS  = 12;
    localparam int          VEL_MAX    = 1023;
    localparam int          VEL_MIN    = -1024;

    // register index with no register behind it; writes must be ignored
    localparam logic [1:0]  CFG_UNUSED = 2'd3;

    localparam int          DATA_BITS = 3 * VEL_W + 6 * WORD_W;     // 135, bit 135 is pad

    typedef logic [STORE_DEPTH-1:0][7:0] payload_t;

    // One decoded frame as it appears on m_axis
    typedef struct packed {
        logic                     status;
        logic [2:0][VEL_W-1:0]    vel;     // forward, sideways, turn
        logic [5:0][WORD_W-1:0]   word;    // accel x/y/z, rate x/y/z
    } frame_result_t;

    // Directed stimulus: optional lead-in bytes, then FE FE + payload + checksum
    typedef struct packed {
        logic [2:0]           lead_n;
        logic [3:0][7:0]      lead;        // lead[0] goes first
        payload_t             payload;
        logic                 corrupt;     // send checksum off by one
        logic                 typed;       // use want below instead of the decoder
        frame_result_t        want;
    } stim_row_t;

    localparam frame_result_t ALL_LOW  = {1'b0, {3{-11'sd128}}, {6{-17'sd10000}}};
    localparam frame_result_t ALL_HIGH = {1'b0, {3{11'sd127}}, {6{17'sd55535}}};
    localparam frame_result_t BAD_SUM  = {1'b1, {DATA_BITS{1'b0}}};
    localparam frame_result_t CENTRED  = '0;
    localparam frame_result_t NO_WANT  = '0;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // broken header (FE then 00), then all-zero payload: lowest values everywhere
        {3'd2, {8'h00, 8'h00, 8'h00, 8'hFE}, {15{8'h00}}, 1'b0, 1'b1, ALL_LOW},
        // all-ones payload: highest values everywhere
        {3'd0, 32'h0, {15{8'hFF}}, 1'b0, 1'b1, ALL_HIGH},
        // checksum mismatch: status set, every field zero
        {3'd1, {8'h00, 8'h00, 8'h00, 8'h7F}, {15{8'hFF}}, 1'b1, 1'b1, BAD_SUM},
        // noise, lone FE, then a frame carrying FE FE inside its payload
        {3'd3, {8'h00, 8'h01, 8'hFE, 8'h55},
         {8'hFE, 8'h00, 8'h01, 8'hFF, 8'hFE, 8'h80, 8'h00, 8'h7F,
          8'h10, 8'h27, 8'hFE, 8'hFE, 8'h00, 8'hFF, 8'h01}, 1'b0, 1'b0, NO_WANT},
        // velocity bytes at 128 and words at 10000: every field zero
        {3'd0, 32'h0, {{6{8'h27, 8'h10}}, {3{8'h80}}}, 1'b0, 1'b1, CENTRED},
        // velocity bytes at and one either side of centre, mixed words
        {3'd0, 32'h0,
         {8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF0,
          8'h0F, 8'hED, 8'hCB, 8'hA9, 8'h80, 8'h7F, 8'h81}, 1'b0, 1'b0, NO_WANT}
    };

    localparam logic [7:0] VEL_EXTREMES [7] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'h81, 8'hFE, 8'hFF};

    string VEL_NAMES  [3] = '{"vel_forward", "vel_sideways", "vel_turn"};
    string WORD_NAMES [6] = '{"accel_x", "accel_y", "accel_z", "rate_x", "rate_y", "rate_z"};

    // ---------------------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ---------------------------------------------------------------------------------
    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           s_tvalid  = 1'b0;
    logic           s_tready;
    logic [7:0]     s_tdata   = 8'h00;
    logic           m_tvalid;
    logic           m_tready  = 1'b0;
    logic [135:0]   m_tdata;
    logic           m_tuser;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [1:0]     cfg_index = 2'd0;
    logic [15:0]    cfg_data  = 16'h0000;

    odometry_imu_frame_receiver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ---------------------------------------------------------------------------------
    // Decoder state, mirrors the block's framing and gain registers
    // ---------------------------------------------------------------------------------
    phase_t                   track_phase = PH_HUNT1;
    int                       taken_count = 0;
    logic [7:0]               running_sum = 8'h00;
    logic [7:0]               held_bytes [STORE_DEPTH];
    logic signed [GAIN_W-1:0] gain_reg [3] = '{GAIN_RESET, GAIN_RESET, GAIN_RESET};

    frame_result_t            frames_due [$];    // decoded frames not yet seen on m_axis

    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  bytes_sent     = 0;
    int  frames_checked = 0;
    int  bad_frames     = 0;
    int  gain_writes    = 0;
    int  burst_left     = 0;

    // receiver stall pattern
    int  stall_mode = 0;
    int  mode_left  = 0;
    int  hold_left  = 0;

    // ---------------------------------------------------------------------------------
    // Decoder
    // ---------------------------------------------------------------------------------
    function automatic logic [VEL_W-1:0] scaled_speed(input logic [7:0] b,
                                                       input logic signed [GAIN_W-1:0] g);
        int prod;
        int q;
        prod = (int'(b) - VEL_OFFSET) * int'(g) + ROUND_HALF;
        q    = prod >>> FRAC_BITS;                 // floor, so half rounds up
        if (q > VEL_MAX)
            q = VEL_MAX;
        if (q < VEL_MIN)
            q = VEL_MIN;
        return q[VEL_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] offset_word(input logic [7:0] lo, input logic [7:0] hi);
        int w;
        w = int'({hi, lo}) - int'(WORD_OFFSET);
        return w[WORD_W-1:0];
    endfunction

    // Advance the framing state by one byte; returns 1 when a frame beat is due.
    function automatic bit decode_rx_byte(input logic [7:0] b, output frame_result_t res);
        bit done;
        done = 1'b0;
        res  = '0;
        if (track_phase == PH_HUNT2) begin
            if (b == HEADER_BYTE) begin
                track_phase = PH_DATA;
                taken_count = 0;
                running_sum = 8'h00;
            end
            else
                track_phase = PH_HUNT1;    // the non-FE byte is not a new first header
        end
        else if (track_phase != PH_DATA) begin
            if (b == HEADER_BYTE)
                track_phase = PH_HUNT2;
            else
                track_phase = PH_HUNT1;
        end
        else if (taken_count < STORE_DEPTH) begin
            held_bytes[taken_count] = b;
            running_sum             = running_sum + b;
            taken_count++;
        end
        else begin
            // checksum byte closes the frame, good or bad
            done        = 1'b1;
            track_phase = PH_HUNT1;
            taken_count = 0;
            if (running_sum != b)
                res.status = 1'b1;
            else begin
                for (int k = 0; k < 3; k++)
                    res.vel[k] = scaled_speed(held_bytes[k], gain_reg[k]);
                for (int k = 0; k < 6; k++)
                    res.word[k] = offset_word(held_bytes[3 + 2 * k], held_bytes[4 + 2 * k]);
            end
            running_sum = 8'h00;
        end
        return done;
    endfunction

    // ---------------------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH frame %0d %s: got %h, want %h",
                 $realtime, frames_checked, field, got, want);
        mismatch_count++;
    endtask

    task automatic check_result_beat();
        frame_result_t seen;
        frame_result_t due;
        seen.status = m_tuser;
        for (int k = 0; k < 3; k++)
            seen.vel[k] = m_tdata[VEL_W * k +: VEL_W];
        for (int k = 0; k < 6; k++)
            seen.word[k] = m_tdata[3 * VEL_W + WORD_W * k +: WORD_W];
        if (frames_due.size() == 0) begin
            report_mismatch("unexpected beat, status", seen.status, 0);
            return;
        end
        due = frames_due.pop_front();
        if (due.status)
            bad_frames++;
        if (seen.status !== due.status)
            report_mismatch("status", seen.status, due.status);
        for (int k = 0; k < 3; k++)
            if (seen.vel[k] !== due.vel[k])
                report_mismatch(VEL_NAMES[k], seen.vel[k], due.vel[k]);
        for (int k = 0; k < 6; k++)
            if (seen.word[k] !== due.word[k])
                report_mismatch(WORD_NAMES[k], seen.word[k], due.word[k]);
        if (m_tdata[135] !== 1'b0)
            report_mismatch("tdata pad", m_tdata[135], 0);
        frames_checked++;
    endtask

    // Result side: check the beat taken at this edge, then pick next cycle's tready.
    // Modes: always ready, coin toss, mostly stalled, and long alternating holds.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            check_result_beat();
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 80);
        end
        mode_left--;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (hold_left == 0) begin
                    hold_left = $urandom_range(1, 24);
                    m_tready <= ~m_tready;
                end
                else
                    hold_left--;
            end
        endcase
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d frames still due", cycle_count,
                     frames_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Byte stream side
    // ---------------------------------------------------------------------------------
    // One byte beat. Bursts of random length with random gaps; tvalid stays high
    // across back-to-back beats, so it is only ever assigned once per edge.
    task automatic send_byte(input logic [7:0] b, input bit typed, input frame_result_t want);
        frame_result_t decoded;
        int            gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                gap        = 0;                          // a long unbroken run
                burst_left = $urandom_range(40, 120);
            end
            else begin
                gap        = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 10);
            end
            repeat (gap) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        if (decode_rx_byte(b, decoded))
            frames_due.push_back(typed ? want : decoded);
    endtask

    // FE FE, 15 payload bytes, then the checksum plus sum_err (0 keeps it good)
    task automatic send_frame(input payload_t pl, input logic [7:0] sum_err, input bit typed,
                              input frame_result_t want);
        logic [7:0] sum;
        sum = 8'h00;
        for (int i = 0; i < STORE_DEPTH; i++)
            sum = sum + pl[i];
        send_byte(HEADER_BYTE, 1'b0, NO_WANT);
        send_byte(HEADER_BYTE, 1'b0, NO_WANT);
        for (int i = 0; i < STORE_DEPTH; i++)
            send_byte(pl[i], 1'b0, NO_WANT);
        send_byte(sum + sum_err, typed, want);
    endtask

    function automatic payload_t random_payload();
        payload_t pl;
        for (int i = 0; i < STORE_DEPTH; i++)
            pl[i] = 8'($urandom);
        // lean the velocity bytes towards centre and ends, where rounding and clipping live
        for (int i = 0; i < 3; i++)
            if ($urandom_range(0, 3) == 0)
                pl[i] = VEL_EXTREMES[$urandom_range(0, 6)];
        return pl;
    endfunction

    // Mostly good frames with random content; the rest bad sums, broken headers, noise
    task automatic send_random_unit();
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            send_frame(random_payload(), 8'h00, 1'b0, NO_WANT);
        else if (pick < 80)
            send_frame(random_payload(), 8'($urandom_range(1, 255)), 1'b0, NO_WANT);
        else if (pick < 88) begin
            b = 8'($urandom_range(0, 254));
            if (b == HEADER_BYTE)
                b = 8'hFF;
            send_byte(HEADER_BYTE, 1'b0, NO_WANT);
            send_byte(b, 1'b0, NO_WANT);
        end
        else
            repeat ($urandom_range(1, 4)) begin
                b = ($urandom_range(0, 2) == 0) ? HEADER_BYTE : 8'($urandom);
                send_byte(b, 1'b0, NO_WANT);
            end
    endtask

    // Hold the stream until every due frame has come out, then let the pipeline settle.
    // A frame may be half collected inside the block; it stays there until the stream resumes.
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_gain(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FORWARD_GAIN:  gain_reg[0] = val;
            CFG_SIDEWAYS_GAIN: gain_reg[1] = val;
            CFG_TURN_GAIN:     gain_reg[2] = val;
            default: ;
        endcase
        gain_writes++;
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------------------
    int         phase_start;
    bit         paused;
    logic [15:0] g0, g1, g2;

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames at reset gains
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            for (int i = 0; i < DIRECTED[r].lead_n; i++)
                send_byte(DIRECTED[r].lead[i], 1'b0, NO_WANT);
            send_frame(DIRECTED[r].payload, DIRECTED[r].corrupt ? 8'h01 : 8'h00,
                       DIRECTED[r].typed, DIRECTED[r].want);
        end

        // random traffic, one gain setting per phase; gains change only while idle
        for (int p = 0; p < GAIN_PHASES; p++) begin
            wait_results_done();
            case (p)
                0:
                begin
                    g0 = 16'h7FFF; g1 = 16'h8000; g2 = 16'h0000;    // clipping both ways
                end
                1:
                begin
                    g0 = 16'h8000; g1 = 16'h7FFF; g2 = 16'h0800;    // half gain: ties
                end
                2:
                begin
                    g0 = 16'hF800; g1 = 16'h0001; g2 = 16'hFFFF;    // tiny and negative half
                end
                3:
                begin
                    g0 = 16'($urandom); g1 = 16'($urandom); g2 = 16'($urandom);
                end
                4:
                begin
                    g0 = 16'($urandom_range(0, 16383) - 8192);
                    g1 = 16'($urandom_range(0, 16383) - 8192);
                    g2 = 16'($urandom_range(0, 16383) - 8192);
                end
                default:
                begin
                    g0 = GAIN_RESET; g1 = GAIN_RESET; g2 = GAIN_RESET;
                end
            endcase
            write_gain(CFG_FORWARD_GAIN, g0);
            write_gain(CFG_SIDEWAYS_GAIN, g1);
            write_gain(CFG_TURN_GAIN, g2);
            if (p == 3)
                write_gain(CFG_UNUSED, 16'($urandom));    // must leave all gains alone
            phase_start = bytes_sent;
            paused      = 1'b0;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                // mid-phase: stop sending until the block has emptied out
                if (!paused && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
                    wait_results_done();
                    paused = 1'b1;
                end
                send_random_unit();
            end
        end

        wait_results_done();
        $display("Sent %0d bytes over %0d gain settings with %0d gain writes",
                 bytes_sent, GAIN_PHASES + 1, gain_writes);
        $display("Checked %0d frame beats, %0d of them checksum mismatches",
                 frames_checked, bad_frames);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: odometry_imu_frame_receiver.f
rtl/oimu_pkg.sv
rtl/oimu_front.sv
rtl/oimu_queue.sv
rtl/oimu_back.sv
rtl/odometry_imu_frame_receiver.sv
tb/tb_odometry_imu_frame_receiver.sv
